// ===== rtl/core/rpc_pkg.sv =====
// Shared types and constants for the point rotation pipeline.
// Holds datapath widths, the CORDIC gain, the arctangent table and stage structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rpc_pkg;

	localparam int COORD_W = 24;              // Q16.8 coordinate
	localparam int ANGLE_W = 16;              // binary angle, 2^16 per turn
	localparam int OFS_W   = COORD_W + 1;     // exact point minus center
	localparam int GUARD   = 16;              // extra fraction bits in the datapath
	localparam int XW      = 42;              // x/y datapath width
	localparam int ZW      = 32;              // angle accumulator, 2^32 per turn
	localparam int GAIN_W  = 32;
	localparam int MW      = OFS_W + GAIN_W + 1;
	localparam int SUM_W   = XW - GUARD + 2;  // rounded result plus center
	localparam int MAX_TABLE = 24;
	localparam int IN_W    = 4 * COORD_W + ANGLE_W;
	localparam int OUT_W   = 2 * COORD_W;

	localparam logic [GAIN_W-1:0] GAIN_Q32 = 32'd2608131496;

	localparam logic signed [COORD_W-1:0] OUT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] OUT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// offset vector and center as it moves down the cell chain
	typedef struct packed {
		logic signed [XW-1:0]      x;
		logic signed [XW-1:0]      y;
		logic signed [ZW-1:0]      z;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
	} rpc_vec_t;

	typedef struct packed {
		logic                      clipped;
		logic signed [COORD_W-1:0] ry;
		logic signed [COORD_W-1:0] rx;
	} rpc_res_t;

	// atan(2^-i) in units of 2^32 per turn, rounded to nearest
	function automatic logic [ZW-1:0] atan_entry(input int unsigned idx);
		logic [ZW-1:0] v;
		case (idx)
			0:  v = 32'd536870912;
			1:  v = 32'd316933406;
			2:  v = 32'd167458907;
			3:  v = 32'd85004756;
			4:  v = 32'd42667331;
			5:  v = 32'd21354465;
			6:  v = 32'd10679838;
			7:  v = 32'd5340245;
			8:  v = 32'd2670163;
			9:  v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rpc_prep.sv =====
// Front end: offset from center, quarter-turn fold, gain scaling.
// Two registered stages feeding the first CORDIC cell. Uses rpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpc_prep (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire logic [rpc_pkg::IN_W-1:0]   in_data,
	output logic                            out_valid,
	output rpc_pkg::rpc_vec_t               out_data
);
	import rpc_pkg::*;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	logic signed [COORD_W-1:0] point_x, point_y, center_x, center_y;
	logic [ANGLE_W-1:0]        rotation_angle;
	logic signed [OFS_W-1:0]   dx, dy, qx, qy;
	logic [ANGLE_W-1:0]        ang_bias, rest;
	logic [1:0]                quad;

	logic                      valid_s1;
	logic signed [OFS_W-1:0]   qx_s1, qy_s1;
	logic signed [ANGLE_W-1:0] rest_s1;
	logic signed [COORD_W-1:0] cx_s1, cy_s1;

	logic signed [MW-1:0]      prod_x, prod_y, rnd_x, rnd_y;
	logic                      valid_s2;
	rpc_vec_t                  vec_s2;

	assign point_x        = in_data[COORD_W-1:0];
	assign point_y        = in_data[2*COORD_W-1:COORD_W];
	assign center_x       = in_data[3*COORD_W-1:2*COORD_W];
	assign center_y       = in_data[4*COORD_W-1:3*COORD_W];
	assign rotation_angle = in_data[IN_W-1:4*COORD_W];

	assign dx = {point_x[COORD_W-1], point_x} - {center_x[COORD_W-1], center_x};
	assign dy = {point_y[COORD_W-1], point_y} - {center_y[COORD_W-1], center_y};

	// nearest quarter turn; the rest wraps into [-1/8, +1/8) of a turn
	assign ang_bias = rotation_angle + 16'h2000;
	assign quad     = ang_bias[ANGLE_W-1:ANGLE_W-2];
	assign rest     = rotation_angle - {quad, {(ANGLE_W-2){1'b0}}};

	always_comb begin
		case (quad)
			QUAD_0: begin
				qx = dx;
				qy = dy;
			end
			QUAD_1: begin
				qx = -dy;
				qy = dx;
			end
			QUAD_2: begin
				qx = -dx;
				qy = -dy;
			end
			default: begin
				qx = dy;
				qy = -dx;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s1   <= qx;
			qy_s1   <= qy;
			rest_s1 <= rest;
			cx_s1   <= center_x;
			cy_s1   <= center_y;
		end
	end

	// scale by the CORDIC gain, round half up into the guard format
	assign prod_x = qx_s1 * $signed({1'b0, GAIN_Q32});
	assign prod_y = qy_s1 * $signed({1'b0, GAIN_Q32});
	assign rnd_x  = prod_x + $signed(MW'(1) <<< (GUARD - 1));
	assign rnd_y  = prod_y + $signed(MW'(1) <<< (GUARD - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s2.x  <= rnd_x[MW-1:GUARD];
			vec_s2.y  <= rnd_y[MW-1:GUARD];
			vec_s2.z  <= {rest_s1, {(ZW-ANGLE_W){1'b0}}};
			vec_s2.cx <= cx_s1;
			vec_s2.cy <= cy_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = vec_s2;

endmodule

`default_nettype wire

// ===== rtl/core/rpc_cell.sv =====
// One CORDIC rotation-mode micro-rotation with a fixed shift, registered.
// Cells are chained by the top level. Uses rpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpc_cell #(
	parameter int IDX = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  rpc_pkg::rpc_vec_t     in_data,
	output logic                  out_valid,
	output rpc_pkg::rpc_vec_t     out_data
);
	import rpc_pkg::*;

	localparam logic signed [ZW-1:0] ATAN = $signed(atan_entry(IDX));

	logic signed [XW-1:0] xs, ys;
	logic                 ccw;
	rpc_vec_t             nxt;

	assign xs  = in_data.x >>> IDX;
	assign ys  = in_data.y >>> IDX;
	assign ccw = !in_data.z[ZW-1];

	always_comb begin
		nxt = in_data;
		if (ccw) begin
			nxt.x = in_data.x - ys;
			nxt.y = in_data.y + xs;
			nxt.z = in_data.z - ATAN;
		end else begin
			nxt.x = in_data.x + ys;
			nxt.y = in_data.y - xs;
			nxt.z = in_data.z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rpc_post.sv =====
// Back end: round to Q16.8, add the center, saturate, and hold the result
// in an output register backed by one spare entry. Uses rpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpc_post (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  rpc_pkg::rpc_vec_t     in_data,
	output logic                  en,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output rpc_pkg::rpc_res_t     out_data
);
	import rpc_pkg::*;

	logic signed [XW:0]        rnd_x, rnd_y;
	logic signed [SUM_W-1:0]   sum_x, sum_y;
	logic                      clip_x, clip_y;
	rpc_res_t                  res;

	logic                      out_valid_q, spare_valid_q;
	rpc_res_t                  out_q, spare_q;
	logic                      take_in, out_free;

	assign rnd_x = {in_data.x[XW-1], in_data.x} + $signed((XW+1)'(1) <<< (GUARD - 1));
	assign rnd_y = {in_data.y[XW-1], in_data.y} + $signed((XW+1)'(1) <<< (GUARD - 1));
	assign sum_x = SUM_W'($signed(rnd_x[XW:GUARD])) + SUM_W'(in_data.cx);
	assign sum_y = SUM_W'($signed(rnd_y[XW:GUARD])) + SUM_W'(in_data.cy);

	always_comb begin
		clip_x = 1'b1;
		clip_y = 1'b1;
		if (sum_x > SUM_W'(OUT_MAX)) begin
			res.rx = OUT_MAX;
		end else if (sum_x < SUM_W'(OUT_MIN)) begin
			res.rx = OUT_MIN;
		end else begin
			res.rx = sum_x[COORD_W-1:0];
			clip_x = 1'b0;
		end
		if (sum_y > SUM_W'(OUT_MAX)) begin
			res.ry = OUT_MAX;
		end else if (sum_y < SUM_W'(OUT_MIN)) begin
			res.ry = OUT_MIN;
		end else begin
			res.ry = sum_y[COORD_W-1:0];
			clip_y = 1'b0;
		end
		res.clipped = clip_x | clip_y;
	end

	// the chain freezes only once the spare holds a beat
	assign en       = !spare_valid_q;
	assign take_in  = in_valid && en;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q   <= spare_valid_q || take_in;
			spare_valid_q <= 1'b0;
		end else if (take_in) begin
			spare_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (spare_valid_q) begin
				out_q <= spare_q;
			end else if (take_in) begin
				out_q <= res;
			end
		end else if (take_in) begin
			spare_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	property p_spare_needs_out;
		@(posedge clk) disable iff (!arst_n)
		spare_valid_q |-> out_valid_q;
	endproperty
	a_spare_needs_out: assert property (p_spare_needs_out)
		else $error("spare entry holds a beat while output register is empty");

	property p_spare_fill_on_stall;
		@(posedge clk) disable iff (!arst_n)
		(!spare_valid_q && out_valid_q && !out_ready && in_valid) |=> spare_valid_q;
	endproperty
	a_spare_fill_on_stall: assert property (p_spare_fill_on_stall)
		else $error("beat from chain not caught while output stalled");

	property p_spare_drain;
		@(posedge clk) disable iff (!arst_n)
		(spare_valid_q && out_ready) |=> (out_valid_q && !spare_valid_q);
	endproperty
	a_spare_drain: assert property (p_spare_drain)
		else $error("spare entry not moved to output register");

endmodule

`default_nettype wire

// ===== rtl/core/rotate_point_about_center_top.sv =====
// Top level: rotates a Q16.8 point about a center by a binary angle.
// Chains rpc_prep, ITERATIONS rpc_cell instances and rpc_post. Uses rpc_pkg.
//
//  channel | dir | payload
//  s_*     | in  | tdata: point_x, point_y, center_x, center_y, rotation_angle
//  m_*     | out | tdata: rotated_x, rotated_y; tuser: clipped
//
// One beat accepted per cycle while s_tready is high. Each beat passes through
// two front-end stages, one cell per iteration and the output register.
// Front end and cells advance together; a stalled output parks one beat in a
// spare entry, then freezes the chain and drops s_tready until the spare drains.
// Reset clears valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module rotate_point_about_center_top #(
	parameter int ITERATIONS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// [23:0] point_x, [47:24] point_y, [71:48] center_x, [95:72] center_y,
	// [111:96] rotation_angle
	input  wire logic [rpc_pkg::IN_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// [23:0] rotated_x, [47:24] rotated_y
	output logic [rpc_pkg::OUT_W-1:0]       m_tdata,
	// [0] clipped
	output logic                            m_tuser
);
	import rpc_pkg::*;

	logic                en;
	logic [ITERATIONS:0] chain_valid;
	rpc_vec_t            chain_data [0:ITERATIONS];
	rpc_res_t            res;

	assign s_tready = en;

	rpc_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid && en),
		.in_data   (s_tdata),
		.out_valid (chain_valid[0]),
		.out_data  (chain_data[0])
	);

	for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
		rpc_cell #(
			.IDX (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_valid[k]),
			.in_data   (chain_data[k]),
			.out_valid (chain_valid[k+1]),
			.out_data  (chain_data[k+1])
		);
	end

	rpc_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[ITERATIONS]),
		.in_data   (chain_data[ITERATIONS]),
		.en        (en),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	assign m_tdata = {res.ry, res.rx};
	assign m_tuser = res.clipped;

	property p_frozen_chain_holds;
		@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(chain_valid);
	endproperty
	a_frozen_chain_holds: assert property (p_frozen_chain_holds)
		else $error("cell chain moved while frozen");

	// the second front-end stage loads only on a cycle where the chain advances
	property p_accept_enters_chain;
		@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 en |=> chain_valid[0];
	endproperty
	a_accept_enters_chain: assert property (p_accept_enters_chain)
		else $error("accepted beat missing from front end");

	property p_last_cell_lands;
		@(posedge clk) disable iff (!arst_n)
		(chain_valid[ITERATIONS] && en) |=> m_tvalid;
	endproperty
	a_last_cell_lands: assert property (p_last_cell_lands)
		else $error("beat from last cell did not reach output");

endmodule

`default_nettype wire
